// ----- src/sce_pkg.sv -----
// Package: shared types and constants of the speed cost evaluator
`timescale 1ns / 1ps
package sce_pkg;

  localparam int unsigned CostW = 32;

  localparam logic [CostW-1:0] CostMax = '1;

  typedef enum logic [2:0] {
    REG_UNIT_TIME  = 3'd0,
    REG_STOP_SPEED = 3'd1,
    REG_SPEED_COST = 3'd2,
    REG_KEEP_CLEAR = 3'd3,
    REG_EXCEED     = 3'd4,
    REG_LOW_SPEED  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SPEED,
    ST_SCAN,
    ST_KC,
    ST_DIV_RATIO,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_E,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;       // latch the input transaction
    logic div_speed;  // start speed division
    logic div_ratio;  // start shortfall division
    logic div_step;   // one divider iteration
    logic scan_step;  // compare one stored interval
    logic latch_spd;  // hold speed, term flags and keep-clear hit
    logic mul_a;
    logic mul_b;
    logic mul_c;
    logic mul_d;
    logic mul_e;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic func;
    logic neg;
    logic div_done;
    logic scan_done;
    logic under;
  } dp_sts_t;

  typedef struct packed {
    logic [15:0] unit_time;
    logic [15:0] max_stop_speed;
    logic [15:0] speed_scale;
    logic [15:0] keep_clear_penalty;
    logic [15:0] over_weight;
    logic [15:0] under_weight;
  } cfg_regs_t;

endpackage

// ----- src/sce_if.sv -----
// Interfaces: input and result channels
`timescale 1ns / 1ps
interface sce_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [19:0] s_first;
  logic [19:0] s_second;
  logic [15:0] max_speed;
  logic [19:0] range_start;
  logic [19:0] range_end;
  modport source (output valid, func, s_first, s_second, max_speed, range_start,
                  range_end, input ready);
  modport sink (input valid, func, s_first, s_second, max_speed, range_start,
                range_end, output ready);
endinterface

interface sce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cost;
  logic        cost_infinite;
  logic        table_full;
  modport source (output valid, cost, cost_infinite, table_full, input ready);
  modport sink (input valid, cost, cost_infinite, table_full, output ready);
endinterface

// ----- src/speed_cost_evaluator.sv -----
// Top level: speed cost evaluator with register port
// channel | dir | handshake
// in_     | in  | valid/ready, one transaction per operation
// out_    | out | valid/ready, one result per operation
// cfg_    | in  | APB-style register writes and reads
// An add or a negative-speed evaluate skips the divider; an evaluate runs the
// serial 32-step divider for the speed and, when the speed is under the limit,
// again for the shortfall; a new transaction is accepted only after the last.
// rst_n is synchronous; it clears the zone count and restores register defaults.
// A result not yet taken holds the controller in its output state.
`timescale 1ns / 1ps
module speed_cost_evaluator #(
  parameter int unsigned ZONE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sce_in_if.sink      in_ch,
  sce_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sce_pkg::*;

  cfg_regs_t cfg_r;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  reg_idx_t  idx;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'd717, 16'd51, 16'd256, 16'd2560, 16'd2560, 16'd2560};
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      unique case (idx)
        REG_UNIT_TIME:  cfg_r.unit_time          <= cfg_pwdata[15:0];
        REG_STOP_SPEED: cfg_r.max_stop_speed     <= cfg_pwdata[15:0];
        REG_SPEED_COST: cfg_r.speed_scale        <= cfg_pwdata[15:0];
        REG_KEEP_CLEAR: cfg_r.keep_clear_penalty <= cfg_pwdata[15:0];
        REG_EXCEED:     cfg_r.over_weight        <= cfg_pwdata[15:0];
        REG_LOW_SPEED:  cfg_r.under_weight       <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_UNIT_TIME:  cfg_prdata = {16'd0, cfg_r.unit_time};
      REG_STOP_SPEED: cfg_prdata = {16'd0, cfg_r.max_stop_speed};
      REG_SPEED_COST: cfg_prdata = {16'd0, cfg_r.speed_scale};
      REG_KEEP_CLEAR: cfg_prdata = {16'd0, cfg_r.keep_clear_penalty};
      REG_EXCEED:     cfg_prdata = {16'd0, cfg_r.over_weight};
      REG_LOW_SPEED:  cfg_prdata = {16'd0, cfg_r.under_weight};
      default:        cfg_prdata = '0;
    endcase
  end

  sce_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  sce_dp #(.ZONE_SLOTS(ZONE_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg(cfg_r),
    .in_func(in_ch.func), .in_s_first(in_ch.s_first), .in_s_second(in_ch.s_second),
    .in_max_speed(in_ch.max_speed), .in_range_start(in_ch.range_start),
    .in_range_end(in_ch.range_end),
    .out_cost(out_ch.cost), .out_cost_infinite(out_ch.cost_infinite),
    .out_table_full(out_ch.table_full)
  );
endmodule

// ----- src/sce_ctrl.sv -----
// Controller: sequences division, zone scan and cost terms
`timescale 1ns / 1ps
module sce_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  sce_pkg::dp_sts_t sts,
  output sce_pkg::dp_cmd_t cmd
);
  import sce_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    ov_nxt    = ov_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV_SPEED;
        end
      end
      ST_DIV_SPEED: begin
        if (!sts.func || sts.neg) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_speed = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // divider and zone scan run together
        if (!sts.div_done) cmd.div_step = 1'b1;
        if (!sts.scan_done) cmd.scan_step = 1'b1;
        if (sts.div_done && sts.scan_done) state_nxt = ST_KC;
      end
      ST_KC: begin
        cmd.latch_spd = 1'b1;
        if (sts.under) begin
          cmd.div_ratio = 1'b1;
          state_nxt     = ST_DIV_RATIO;
        end else begin
          state_nxt = ST_MUL_A;
        end
      end
      ST_DIV_RATIO: begin
        if (!sts.div_done) cmd.div_step = 1'b1;
        else state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_c = 1'b1;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_MUL_E;
      end
      ST_MUL_E: begin
        cmd.mul_e = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r) else $error("result dropped");
  a_out_safe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ov_r || out_ready)) else $error("result overwritten");
`endif
endmodule

// ----- src/sce_dp.sv -----
// Datapath: divider, interval table and cost multiplier
`timescale 1ns / 1ps
module sce_dp #(
  parameter int unsigned ZONE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sce_pkg::dp_cmd_t  cmd,
  output sce_pkg::dp_sts_t  sts,
  input  sce_pkg::cfg_regs_t cfg,
  input  logic              in_func,
  input  logic [19:0]       in_s_first,
  input  logic [19:0]       in_s_second,
  input  logic [15:0]       in_max_speed,
  input  logic [19:0]       in_range_start,
  input  logic [19:0]       in_range_end,
  output logic [31:0]       out_cost,
  output logic              out_cost_infinite,
  output logic              out_table_full
);
  import sce_pkg::*;

  localparam int unsigned IdxW = (ZONE_SLOTS > 1) ? $clog2(ZONE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ZONE_SLOTS + 1);

  logic [19:0] zs_mem [ZONE_SLOTS];
  logic [19:0] ze_mem [ZONE_SLOTS];
  logic [CntW-1:0] cnt_r;

  logic        func_r, neg_r, full_r;
  logic [19:0] s2_r, diff_r;
  logic [15:0] lim_r;
  logic [15:0] ut;

  assign ut = (cfg.unit_time == '0) ? 16'd1 : cfg.unit_time;

  // radix-2 restoring divider: 32-bit dividend, 16-bit divisor
  logic [31:0] dq_r;
  logic [16:0] rem_r;
  logic [15:0] dvs_r;
  logic [5:0]  dcnt_r;
  logic [17:0] rem_sh;
  logic [17:0] rem_sub;

  assign rem_sh  = {rem_r, dq_r[31]};
  assign rem_sub = rem_sh - {2'b0, dvs_r};

  // zone scan
  logic [CntW-1:0] scan_r;
  logic            hit_r;
  logic [19:0]     zs_q, ze_q;
  logic            rd_v_r;

  logic [15:0] speed_r;
  logic        over_r, under_r, kc_r;
  logic [31:0] kcw_r, p_r, sum_r;
  logic [63:0] acc_r;
  logic [47:0] lo_r;
  logic [52:0] term_r, term_v;

  logic [15:0] spd_sat;
  assign spd_sat = (dq_r[31:16] != '0) ? 16'hFFFF : dq_r[15:0];

  // speed term, zero when speed equals the limit or on an add
  assign term_v = (func_r && (over_r || under_r)) ? term_r : '0;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    return (v > 64'hFFFFFFFF) ? CostMax : v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.load && !in_func && cnt_r < CntW'(ZONE_SLOTS)) cnt_r <= cnt_r + 1'b1;
      if (cmd.div_speed || cmd.div_ratio) dcnt_r <= 6'd32;
      else if (cmd.div_step) dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !in_func && cnt_r < CntW'(ZONE_SLOTS)) begin
      zs_mem[cnt_r[IdxW-1:0]] <= in_range_start;
      ze_mem[cnt_r[IdxW-1:0]] <= in_range_end;
    end
    zs_q <= zs_mem[scan_r[IdxW-1:0]];
    ze_q <= ze_mem[scan_r[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      neg_r  <= in_func && (in_s_second < in_s_first);
      full_r <= !in_func && (cnt_r >= CntW'(ZONE_SLOTS));
      s2_r   <= in_s_second;
      diff_r <= in_s_second - in_s_first;
      lim_r  <= in_max_speed;
      sum_r  <= '0;
    end
    if (cmd.div_speed) begin
      dq_r   <= {diff_r, 12'd0};
      dvs_r  <= ut;
      rem_r  <= '0;
      scan_r <= '0;
      rd_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else if (cmd.div_ratio) begin
      dq_r  <= {lim_r - spd_sat, 16'd0};
      dvs_r <= lim_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[17]) begin
        rem_r <= rem_sub[16:0];
        dq_r  <= {dq_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[16:0];
        dq_r  <= {dq_r[30:0], 1'b0};
      end
    end
    if (cmd.scan_step || (rd_v_r && cmd.div_step)) begin
      if (scan_r < cnt_r) scan_r <= scan_r + 1'b1;
      rd_v_r <= scan_r < cnt_r;
      if (rd_v_r && zs_q <= s2_r && ze_q >= s2_r) hit_r <= 1'b1;
    end
    if (cmd.latch_spd) begin
      speed_r <= spd_sat;
      over_r  <= spd_sat > lim_r;
      under_r <= spd_sat < lim_r;
      kc_r    <= hit_r && (spd_sat < cfg.max_stop_speed);
      kcw_r   <= 32'(cfg.keep_clear_penalty) * 32'(cfg.speed_scale);
    end
    if (cmd.mul_a) begin
      p_r   <= 32'(cfg.speed_scale) * 32'(over_r ? cfg.over_weight : cfg.under_weight);
      sum_r <= kc_r ? sat32((64'(kcw_r) * 64'(ut)) >> 12) : '0;
    end
    // ratio is Q0.16 and reaches 1.0 at zero speed, hence 17 bits
    if (cmd.mul_b) acc_r <= over_r ? 64'(speed_r) * 64'(speed_r) : 64'(dq_r[16:0]);
    if (cmd.mul_c) acc_r <= 64'(p_r) * 64'(acc_r[31:0]);
    // product times unit time over 2^28, low and high words in turn
    if (cmd.mul_d) lo_r <= 48'(acc_r[31:0]) * 48'(ut);
    if (cmd.mul_e) term_r <= ((53'(acc_r[63:32]) * 53'(ut)) << 4) + 53'(lo_r >> 28);
    if (cmd.out_load) begin
      out_cost_infinite <= neg_r;
      out_table_full    <= full_r;
      out_cost          <= neg_r ? CostMax : sat32(64'(sum_r) + 64'(term_v));
    end
  end

  assign sts.func      = func_r;
  assign sts.neg       = neg_r;
  assign sts.div_done  = (dcnt_r == '0);
  assign sts.scan_done = !rd_v_r && (scan_r >= cnt_r);
  assign sts.under     = spd_sat < lim_r;

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(ZONE_SLOTS)) else $error("zone count overflow");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> dcnt_r != '0) else $error("divider overrun");
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && neg_r |-> !full_r) else $error("flag clash");
`endif
endmodule
